>>> hdl/wfbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfbt_pkg
// Shared types and constants of the window line-fit baseline tracker.
// ----------------------------------------------------------------------------
package wfbt_pkg;

	localparam int WIN_MAX   = 64;
	localparam int WIN_AW    = 6;
	localparam int SMP_W     = 16;
	localparam int CNT_W     = 11;
	localparam int BASE_W    = 24;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// register addresses (word index, paddr[3:2])
	localparam logic [1:0] REG_WIN_LEN   = 2'd0;
	localparam logic [1:0] REG_START_POS = 2'd1;
	localparam logic [1:0] REG_THR_SQ    = 2'd2;

	// request modes
	localparam logic [1:0] MODE_JUDGE   = 2'd0;
	localparam logic [1:0] MODE_UPDATE  = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	typedef struct packed {
		logic        [1:0]       mode;
		logic signed [SMP_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic                     fit_done;
		logic                     fit_passed;
		logic                     is_stable;
		logic                     update_held;
		logic signed [BASE_W-1:0] baseline_value;
		logic        [31:0]       residual_mean_sq;
	} res_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WALK   = 6'b000010,
		ST_MATH   = 6'b000100,
		ST_DIV1   = 6'b001000,
		ST_DIV2   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	// multiply sequencer steps
	typedef enum logic [3:0] {
		MS_NSYY   = 4'd0,
		MS_SYSY   = 4'd1,
		MS_NSXY   = 4'd2,
		MS_SXSY   = 4'd3,
		MS_NSXX   = 4'd4,
		MS_SXSX   = 4'd5,
		MS_BBLO   = 4'd6,
		MS_BBHI   = 4'd7,
		MS_DALO   = 4'd8,
		MS_DAHI   = 4'd9,
		MS_DNN    = 4'd10,
		MS_DSY    = 4'd11,
		MS_BNN1   = 4'd12,
		MS_DN     = 4'd13,
		MS_DRAIN  = 4'd14
	} mstep_t;

endpackage
`default_nettype wire

>>> hdl/window_fit_baseline_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_fit_baseline_tracker_top
// Sliding-window least-squares fit of signed samples with a tracked baseline.
// ----------------------------------------------------------------------------
// Sequence: a request with no fit (restart, unused mode, too early) goes straight to
//   retire; a fit walks the ring over the window (n = clamped window length), runs
//   15 multiply steps, two divisions in the shared divider, then retires.
// Flow: one request in flight; the next is accepted once the result registers,
//   which waits while the previous result is still held.
// Reset: control, pointers, flags and baseline clear at once; the ring is not cleared.

module window_fit_baseline_tracker_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	output logic                          req_ready,
	input  wfbt_pkg::req_t                req,
	output logic                          res_valid,
	input  wire                           res_ready,
	output wfbt_pkg::res_t                res,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [wfbt_pkg::ADDR_W-1:0]   paddr,
	input  wire  [wfbt_pkg::DATA_W-1:0]   pwdata,
	output logic [wfbt_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	// ---------------- configuration registers ----------------
	logic [6:0]  win_len_q;
	logic [9:0]  start_pos_q;
	logic [31:0] thr_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= 7'd16;
			start_pos_q <= 10'd0;
			thr_q       <= 32'd16;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				wfbt_pkg::REG_WIN_LEN:   win_len_q   <= pwdata[6:0];
				wfbt_pkg::REG_START_POS: start_pos_q <= pwdata[9:0];
				wfbt_pkg::REG_THR_SQ:    thr_q       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			wfbt_pkg::REG_WIN_LEN:   prdata = {25'd0, win_len_q};
			wfbt_pkg::REG_START_POS: prdata = {22'd0, start_pos_q};
			wfbt_pkg::REG_THR_SQ:    prdata = thr_q;
			default:                 prdata = '0;
		endcase
	end

	// ---------------- control state ----------------
	wfbt_pkg::state_t state_q;
	wfbt_pkg::mstep_t step_q;

	logic [5:0]  wp_q;
	logic [10:0] cnt_q;
	logic        stable_q;
	logic        held_q;
	logic signed [23:0] base_q;

	// per-request context
	logic [1:0]         mode_q;
	logic signed [15:0] sample_q;
	logic               fit_q;
	logic [6:0]         n_q;
	logic [12:0]        nn_q;
	logic [12:0]        nn1_q;

	logic req_acc;
	assign req_ready = (state_q == wfbt_pkg::ST_IDLE);
	assign req_acc   = req_valid && req_ready;

	// clamp window length to [2, 64]
	logic [6:0]  n_c;
	logic [10:0] cnt_nx;
	logic        fit_c;
	always_comb begin
		if (win_len_q < 7'd2)
			n_c = 7'd2;
		else if (win_len_q > 7'd64)
			n_c = 7'd64;
		else
			n_c = win_len_q;
		cnt_nx = (cnt_q == 11'h7FF) ? cnt_q : cnt_q + 11'd1;
		priority if (req.mode == wfbt_pkg::MODE_JUDGE)
			fit_c = cnt_nx >= ({1'b0, start_pos_q} + {4'd0, n_c});
		else if (req.mode == wfbt_pkg::MODE_UPDATE)
			fit_c = cnt_nx >= {4'd0, n_c};
		else
			fit_c = 1'b0;
	end

	// sample ring (registered read)
	logic signed [15:0] ring_mem [0:wfbt_pkg::WIN_MAX-1];
	logic signed [15:0] rd_data_q;
	logic [5:0]         rd_addr;
	logic [6:0]         walk_idx_q;
	logic               rd_vld_s1;
	logic [5:0]         rd_i_s1;
	logic               ring_we;

	assign ring_we = req_acc &&
		(req.mode == wfbt_pkg::MODE_JUDGE || req.mode == wfbt_pkg::MODE_UPDATE);
	// oldest sample of the window first
	assign rd_addr = wp_q - n_q[5:0] + walk_idx_q[5:0];

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[wp_q] <= req.sample;
		rd_data_q <= ring_mem[rd_addr];
	end

	// ---------------- window sums ----------------
	logic signed [22:0] sy_q;
	logic        [36:0] syy_q;
	logic signed [27:0] sxy_q;
	logic        [10:0] sx_q;
	logic        [16:0] sxx_q;

	logic signed [31:0] yy;
	logic signed [22:0] iy;
	logic        [11:0] ii;
	assign yy = rd_data_q * rd_data_q;
	assign iy = $signed({1'b0, rd_i_s1}) * rd_data_q;
	assign ii = rd_i_s1 * rd_i_s1;

	// ---------------- shared multiplier ----------------
	logic [37:0] ma;
	logic [23:0] mb;
	logic [61:0] prod_q;
	logic [21:0] sy_abs;
	logic [26:0] sxy_abs;
	logic [31:0] b_abs;

	logic        [43:0] a_q;
	logic signed [34:0] b_q;
	logic        [22:0] d_q;
	logic        [63:0] bb_q;
	logic        [63:0] ad_q;
	logic        [33:0] den_q;
	logic signed [45:0] s_q;
	logic        [27:0] bot_q;

	logic signed [34:0] b_neg;
	logic signed [22:0] sy_neg;
	logic signed [27:0] sxy_neg;
	assign sy_neg  = -sy_q;
	assign sxy_neg = -sxy_q;
	assign b_neg   = -b_q;
	assign sy_abs  = sy_q[22]  ? sy_neg[21:0]  : sy_q[21:0];
	assign sxy_abs = sxy_q[27] ? sxy_neg[26:0] : sxy_q[26:0];
	assign b_abs   = b_q[34]   ? b_neg[31:0]   : b_q[31:0];

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			wfbt_pkg::MS_NSYY: begin ma = {1'b0, syy_q};     mb = {17'd0, n_q};    end
			wfbt_pkg::MS_SYSY: begin ma = {16'd0, sy_abs};   mb = {2'd0, sy_abs};  end
			wfbt_pkg::MS_NSXY: begin ma = {11'd0, sxy_abs};  mb = {17'd0, n_q};    end
			wfbt_pkg::MS_SXSY: begin ma = {16'd0, sy_abs};   mb = {13'd0, sx_q};   end
			wfbt_pkg::MS_NSXX: begin ma = {21'd0, sxx_q};    mb = {17'd0, n_q};    end
			wfbt_pkg::MS_SXSX: begin ma = {27'd0, sx_q};     mb = {13'd0, sx_q};   end
			wfbt_pkg::MS_BBLO: begin ma = {6'd0, b_abs};     mb = {8'd0, b_abs[15:0]};  end
			wfbt_pkg::MS_BBHI: begin ma = {6'd0, b_abs};     mb = {8'd0, b_abs[31:16]}; end
			wfbt_pkg::MS_DALO: begin ma = {17'd0, d_q[20:0]}; mb = {3'd0, a_q[20:0]};  end
			wfbt_pkg::MS_DAHI: begin ma = {17'd0, d_q[20:0]}; mb = {2'd0, a_q[42:21]}; end
			wfbt_pkg::MS_DNN:  begin ma = {17'd0, d_q[20:0]}; mb = {11'd0, nn_q};      end
			wfbt_pkg::MS_DSY:  begin ma = {17'd0, d_q[20:0]}; mb = {2'd0, sy_abs};     end
			wfbt_pkg::MS_BNN1: begin ma = {6'd0, b_abs};      mb = {11'd0, nn1_q};     end
			wfbt_pkg::MS_DN:   begin ma = {17'd0, d_q[20:0]}; mb = {17'd0, n_q};       end
			default: ;
		endcase
	end

	logic signed [34:0] pm35;
	logic signed [45:0] ps46;
	assign pm35 = $signed({1'b0, prod_q[33:0]});
	assign ps46 = $signed({2'b0, prod_q[43:0]});

	// ---------------- shared radix-2 divider ----------------
	logic [63:0] quo_q;
	logic [33:0] rem_q;
	logic [33:0] dvs_q;
	logic [5:0]  div_cnt_q;
	logic [34:0] rem_sh;
	logic        rem_ge;
	logic [33:0] rem_nx;
	assign rem_sh = {rem_q, quo_q[63]};
	assign rem_ge = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = rem_ge ? 34'(rem_sh - {1'b0, dvs_q}) : rem_sh[33:0];

	logic        pass_q;
	logic [31:0] mean_q;
	logic        neg2_q;
	logic signed [23:0] endv_q;

	// endpoint numerator 512*s + bot
	logic signed [55:0] nsum;
	logic signed [55:0] nsum_neg;
	assign nsum     = ($signed({{10{s_q[45]}}, s_q}) <<< 9) + $signed({28'd0, bot_q});
	assign nsum_neg = -nsum;

	// endpoint from the final divider step (quotient and remainder of the last bit),
	// floored for negative numerators, then saturated
	logic [63:0]        mag_f;
	logic signed [64:0] rsig_f;
	logic signed [23:0] endv_final;
	always_comb begin
		mag_f  = {quo_q[62:0], rem_ge} + {63'd0, (neg2_q && (rem_nx != 34'd0))};
		rsig_f = neg2_q ? -$signed({1'b0, mag_f}) : $signed({1'b0, mag_f});
		if (rsig_f > 65'sd8388607)
			endv_final = 24'sh7FFFFF;
		else if (rsig_f < -65'sd8388608)
			endv_final = -24'sh800000;
		else
			endv_final = rsig_f[23:0];
	end

	// ---------------- result register ----------------
	logic res_valid_q;
	wfbt_pkg::res_t res_q;
	logic commit;
	assign commit    = (state_q == wfbt_pkg::ST_FINISH) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// next flags and baseline for the request being retired
	logic               stable_nx;
	logic               held_nx;
	logic signed [23:0] base_nx;
	always_comb begin
		stable_nx = stable_q;
		held_nx   = held_q;
		base_nx   = base_q;
		unique case (mode_q)
			wfbt_pkg::MODE_JUDGE: begin
				if (fit_q && pass_q) begin
					stable_nx = 1'b1;
					base_nx   = {sample_q, 8'd0};
				end
			end
			wfbt_pkg::MODE_UPDATE: begin
				if (fit_q) begin
					if (pass_q)
						base_nx = endv_q;
					else
						held_nx = 1'b1;
				end
			end
			wfbt_pkg::MODE_RESTART: begin
				stable_nx = 1'b0;
				held_nx   = 1'b0;
				base_nx   = '0;
			end
			default: ;
		endcase
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wfbt_pkg::ST_IDLE;
			step_q      <= wfbt_pkg::MS_NSYY;
			wp_q        <= '0;
			cnt_q       <= '0;
			stable_q    <= 1'b0;
			held_q      <= 1'b0;
			base_q      <= '0;
			walk_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				wfbt_pkg::ST_IDLE: begin
					if (req_acc) begin
						if (req.mode == wfbt_pkg::MODE_RESTART) begin
							wp_q  <= '0;
							cnt_q <= '0;
						end else if (ring_we) begin
							wp_q  <= wp_q + 6'd1;
							cnt_q <= cnt_nx;
						end
						walk_idx_q <= '0;
						rd_vld_s1  <= 1'b0;
						state_q    <= fit_c ? wfbt_pkg::ST_WALK : wfbt_pkg::ST_FINISH;
					end
				end
				wfbt_pkg::ST_WALK: begin
					rd_vld_s1 <= walk_idx_q != n_q;
					if (walk_idx_q != n_q)
						walk_idx_q <= walk_idx_q + 7'd1;
					else if (!rd_vld_s1) begin
						step_q  <= wfbt_pkg::MS_NSYY;
						state_q <= wfbt_pkg::ST_MATH;
					end
				end
				wfbt_pkg::ST_MATH: begin
					if (step_q == wfbt_pkg::MS_DRAIN) begin
						div_cnt_q <= 6'd63;
						state_q   <= wfbt_pkg::ST_DIV1;
					end else
						step_q <= wfbt_pkg::mstep_t'(step_q + 4'd1);
				end
				wfbt_pkg::ST_DIV1: begin
					div_cnt_q <= div_cnt_q - 6'd1;
					if (div_cnt_q == 6'd0)
						state_q <= wfbt_pkg::ST_DIV2;
				end
				wfbt_pkg::ST_DIV2: begin
					div_cnt_q <= div_cnt_q - 6'd1;
					if (div_cnt_q == 6'd0)
						state_q <= wfbt_pkg::ST_FINISH;
				end
				wfbt_pkg::ST_FINISH: begin
					if (commit) begin
						stable_q <= stable_nx;
						held_q   <= held_nx;
						base_q   <= base_nx;
						state_q  <= wfbt_pkg::ST_IDLE;
					end
				end
				default: state_q <= wfbt_pkg::ST_IDLE;
			endcase
			// a retiring request refills the output in the cycle it drains
			if (commit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		rd_i_s1 <= walk_idx_q[5:0];
		prod_q  <= ma * mb;

		if (req_acc) begin
			mode_q   <= req.mode;
			sample_q <= req.sample;
			fit_q    <= fit_c;
			n_q      <= n_c;
			nn_q     <= {6'd0, n_c} * {6'd0, n_c};
			nn1_q    <= {6'd0, n_c} * {6'd0, n_c - 7'd1};
			sy_q     <= '0;
			syy_q    <= '0;
			sxy_q    <= '0;
			sx_q     <= '0;
			sxx_q    <= '0;
		end

		if (state_q == wfbt_pkg::ST_WALK && rd_vld_s1) begin
			sy_q  <= sy_q + {{7{rd_data_q[15]}}, rd_data_q};
			syy_q <= syy_q + {6'd0, yy[30:0]};
			sxy_q <= sxy_q + {{5{iy[22]}}, iy};
			sx_q  <= sx_q + {5'd0, rd_i_s1};
			sxx_q <= sxx_q + {5'd0, ii};
		end

		// consume the product of the previous step
		if (state_q == wfbt_pkg::ST_MATH) begin
			unique case (step_q)
				wfbt_pkg::MS_NSYY: ;
				wfbt_pkg::MS_SYSY: a_q <= prod_q[43:0];
				wfbt_pkg::MS_NSXY: a_q <= a_q - prod_q[43:0];
				wfbt_pkg::MS_SXSY: b_q <= sxy_q[27] ? -pm35 : pm35;
				wfbt_pkg::MS_NSXX: b_q <= sy_q[22] ? b_q + pm35 : b_q - pm35;
				wfbt_pkg::MS_SXSX: d_q <= prod_q[22:0];
				wfbt_pkg::MS_BBLO: d_q <= d_q - prod_q[22:0];
				wfbt_pkg::MS_BBHI: bb_q <= {2'd0, prod_q};
				wfbt_pkg::MS_DALO: bb_q <= bb_q + (64'(prod_q) << 16);
				wfbt_pkg::MS_DAHI: ad_q <= {2'd0, prod_q};
				wfbt_pkg::MS_DNN:  ad_q <= ad_q + (64'(prod_q) << 21);
				wfbt_pkg::MS_DSY:  den_q <= prod_q[33:0];
				wfbt_pkg::MS_BNN1: s_q <= sy_q[22] ? -(ps46 <<< 1) : (ps46 <<< 1);
				wfbt_pkg::MS_DN:   s_q <= b_q[34] ? s_q - ps46 : s_q + ps46;
				wfbt_pkg::MS_DRAIN: begin
					bot_q <= {prod_q[26:0], 1'b0};
					// mean residual division: (a*d - b*b) / (n*n*d)
					quo_q <= ad_q - bb_q;
					rem_q <= '0;
					dvs_q <= den_q;
				end
				default: ;
			endcase
		end

		if (state_q == wfbt_pkg::ST_DIV1) begin
			if (div_cnt_q == 6'd0) begin
				mean_q <= ({quo_q[62:0], rem_ge} > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
					: {quo_q[30:0], rem_ge};
				pass_q <= {quo_q[62:0], rem_ge} <= {32'd0, thr_q};
				// endpoint division: (512*s + bot) / (2*bot), floored
				neg2_q <= nsum[55];
				quo_q  <= nsum[55] ? 64'(unsigned'(nsum_neg)) : 64'(unsigned'(nsum));
				rem_q  <= '0;
				dvs_q  <= {5'd0, bot_q, 1'b0};
			end else begin
				quo_q <= {quo_q[62:0], rem_ge};
				rem_q <= rem_nx;
			end
		end

		if (state_q == wfbt_pkg::ST_DIV2) begin
			quo_q <= {quo_q[62:0], rem_ge};
			rem_q <= rem_nx;
			if (div_cnt_q == 6'd0)
				endv_q <= endv_final;
		end

		if (commit) begin
			res_q.fit_done         <= fit_q;
			res_q.fit_passed       <= fit_q && pass_q;
			res_q.is_stable        <= stable_nx;
			res_q.update_held      <= held_nx;
			res_q.baseline_value   <= base_nx;
			res_q.residual_mean_sq <= fit_q ? mean_q : 32'd0;
		end
	end

	// ---------------- assertions ----------------
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q != wfbt_pkg::ST_IDLE))
		else $error("accepted request did not start");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfbt_pkg::ST_DIV1 || state_q == wfbt_pkg::ST_DIV2) |-> (rem_q < dvs_q))
		else $error("divider remainder out of range");

	a_pass_needs_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.fit_passed) |-> res_q.fit_done)
		else $error("pass reported without a fit");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfbt_pkg::ST_WALK) |-> (walk_idx_q <= n_q))
		else $error("ring walk ran past the window");

	a_endv_view: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfbt_pkg::ST_DIV2 && div_cnt_q == 6'd0) |=>
			(endv_q == $past(endv_final)))
		else $error("endpoint capture mismatch");

endmodule
`default_nettype wire

>>> bench/window_fit_baseline_tracker_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_fit_baseline_tracker_top_tb
// Self-checking bench for the window line-fit baseline tracker. Requests are
// driven through the valid/ready channel and predicted in exact 64-bit
// arithmetic. Each result is compared field by field with the oldest
// prediction. The registers are written over APB between phases.
// ----------------------------------------------------------------------------

// Tracks the expected block state and holds the predicted results in order.
class tracker_scoreboard;
	logic [6:0]             win_len;
	logic [9:0]             start_pos;
	logic [31:0]            thr_sq;
	logic signed [15:0]     ring [64];
	bit [5:0]               wr_ptr;
	int unsigned            count;
	bit                     stable;
	bit                     held;
	logic signed [23:0]     baseline;
	wfbt_pkg::res_t         pending [$];
	int unsigned            mismatches;

	function new();
		win_len   = 16;
		start_pos = 0;
		thr_sq    = 16;
		wr_ptr    = 0;
		count     = 0;
		stable    = 0;
		held      = 0;
		baseline  = 0;
		mismatches = 0;
		foreach (ring[i]) ring[i] = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			wfbt_pkg::REG_WIN_LEN:   win_len = val[6:0];
			wfbt_pkg::REG_START_POS: start_pos = val[9:0];
			wfbt_pkg::REG_THR_SQ:    thr_sq = val;
			default: ;
		endcase
	endfunction

	// Least-squares fit over the newest n samples, wrapping like 64-bit unsigned math.
	function bit line_fit(longint unsigned n, output logic [31:0] mean,
			output logic signed [23:0] endv);
		longint unsigned sy, syy, sxy, y, sx, sxx, d, a, b, num, den, q;
		longint top, bot, r;
		int idx;
		sy = 0;
		syy = 0;
		sxy = 0;
		for (longint unsigned i = 0; i < n; i++) begin
			idx = int'((wr_ptr + 64 - n + i) % 64);
			y = {{48{ring[idx][15]}}, ring[idx]};
			sy += y;
			syy += y * y;
			sxy += i * y;
		end
		sx  = n * (n - 1) / 2;
		sxx = (n - 1) * n * (2 * n - 1) / 6;
		d   = n * sxx - sx * sx;
		a   = n * syy - sy * sy;
		b   = n * sxy - sx * sy;
		num = a * d - b * b;
		den = n * n * d;
		q   = num / den;
		mean = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		top = longint'(256 * (2 * d * sy + n * (n - 1) * b));
		bot = longint'(2 * n * d);
		// floor division, halves round up
		r = (2 * top + bot) / (2 * bot);
		if (((2 * top + bot) % (2 * bot)) != 0 && (2 * top + bot) < 0)
			r--;
		if (r > 64'sd8388607)
			r = 64'sd8388607;
		if (r < -64'sd8388608)
			r = -64'sd8388608;
		endv = r[23:0];
		return q <= {32'd0, thr_sq};
	endfunction

	function void note_request(wfbt_pkg::req_t rq);
		wfbt_pkg::res_t ex;
		longint unsigned n;
		logic [31:0] mean;
		logic signed [23:0] endv;
		bit pass;
		n = win_len;
		if (n < 2)
			n = 2;
		if (n > 64)
			n = 64;
		ex = '0;
		if (rq.mode == wfbt_pkg::MODE_RESTART) begin
			wr_ptr = 0;
			count = 0;
			stable = 0;
			held = 0;
			baseline = 0;
		end else if (rq.mode == wfbt_pkg::MODE_JUDGE || rq.mode == wfbt_pkg::MODE_UPDATE) begin
			ring[wr_ptr] = rq.sample;
			wr_ptr++;
			if (count < 2047)
				count++;
			if (rq.mode == wfbt_pkg::MODE_JUDGE) begin
				if (count >= start_pos + n) begin
					pass = line_fit(n, mean, endv);
					ex.fit_done = 1;
					ex.fit_passed = pass;
					ex.residual_mean_sq = mean;
					if (pass) begin
						stable = 1;
						baseline = {rq.sample, 8'd0};
					end
				end
			end else if (count >= n) begin
				pass = line_fit(n, mean, endv);
				ex.fit_done = 1;
				ex.fit_passed = pass;
				ex.residual_mean_sq = mean;
				if (pass)
					baseline = endv;
				else
					held = 1;
			end
		end
		ex.is_stable = stable;
		ex.update_held = held;
		ex.baseline_value = baseline;
		pending.push_back(ex);
	endfunction

	function void check_result(wfbt_pkg::res_t got);
		wfbt_pkg::res_t ex;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h", got);
			return;
		end
		ex = pending.pop_front();
		if (ex !== got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: exp done=%b pass=%b stb=%b held=%b base=%0d msq=%0d",
					ex.fit_done, ex.fit_passed, ex.is_stable, ex.update_held,
					ex.baseline_value, ex.residual_mean_sq);
				$display("          got done=%b pass=%b stb=%b held=%b base=%0d msq=%0d",
					got.fit_done, got.fit_passed, got.is_stable, got.update_held,
					got.baseline_value, got.residual_mean_sq);
			end
		end
	endfunction
endclass

module window_fit_baseline_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 20000;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_ready;
	wfbt_pkg::req_t                req;
	logic                          res_valid;
	logic                          res_ready;
	wfbt_pkg::res_t                res;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [wfbt_pkg::ADDR_W-1:0]   paddr;
	logic [wfbt_pkg::DATA_W-1:0]   pwdata;
	logic [wfbt_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	tracker_scoreboard   sb;
	int unsigned         idle_pct;   // sender idle chance per cycle, percent
	int unsigned         stall_pct;  // receiver stall chance, percent
	int unsigned         quiet_cycles;

	window_fit_baseline_tracker_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Receiver side: random back-pressure at the chosen rate.
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Monitor: sample handshakes at the edge, before the block's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (res_valid && res_ready)
				sb.check_result(res);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("window_fit_baseline_tracker_top_tb failed");
				$finish;
			end
		end
	end

	// Send one request; valid stays up through back-pressure.
	task automatic send_req(logic [1:0] mode, logic signed [15:0] smp);
		wfbt_pkg::req_t r;
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		r.mode = mode;
		r.sample = smp;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// APB write: setup cycle, then access; register lands on the access edge.
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [6:0] wl, logic [9:0] sp, logic [31:0] thr);
		drain();
		reg_write(wfbt_pkg::REG_WIN_LEN, {25'd0, wl});
		reg_write(wfbt_pkg::REG_START_POS, {22'd0, sp});
		reg_write(wfbt_pkg::REG_THR_SQ, thr);
	endtask

	function automatic logic signed [15:0] clip16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[15:0];
	endfunction

	// Mostly noisy ramps of judge/update requests, some raw noise, unused modes and restarts.
	task automatic random_traffic(int unsigned items);
		int unsigned sent;
		int base, slope, noise, len;
		logic [1:0] mode;
		sent = 0;
		while (sent < items) begin
			base  = $signed($urandom_range(65535)) - 32768;
			slope = $signed($urandom_range(400)) - 200;
			case ($urandom_range(4))
				0: noise = 0;
				1: noise = 1;
				2: noise = 4;
				3: noise = 64;
				default: noise = 32768;
			endcase
			len = $urandom_range(90, 5);
			for (int k = 0; k < len && sent < items; k++) begin
				case ($urandom_range(19))
					0: mode = wfbt_pkg::MODE_RESTART;
					1: mode = MODE_UNUSED;
					2, 3, 4, 5, 6, 7: mode = wfbt_pkg::MODE_UPDATE;
					default: mode = wfbt_pkg::MODE_JUDGE;
				endcase
				if (mode == wfbt_pkg::MODE_RESTART && $urandom_range(3) != 0)
					mode = wfbt_pkg::MODE_JUDGE;
				send_req(mode, clip16(base + slope * k +
					$signed($urandom_range(2 * noise)) - noise));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults (n=16, start 0, thr 16).
		send_req(MODE_UNUSED, 16'sd5);                     // unused mode reports state
		send_req(wfbt_pkg::MODE_UPDATE, 16'sd32767);       // update too early
		send_req(wfbt_pkg::MODE_JUDGE, -16'sd32768);       // judge too early
		configure(7'd2, 10'd0, 32'd16);
		send_req(wfbt_pkg::MODE_JUDGE, 16'sd32767);        // fit over extremes
		send_req(wfbt_pkg::MODE_UPDATE, -16'sd32768);
		send_req(wfbt_pkg::MODE_UPDATE, -16'sd32768);
		send_req(wfbt_pkg::MODE_JUDGE, -16'sd32768);
		send_req(wfbt_pkg::MODE_RESTART, 16'sd1234);       // restart, sample dropped
		send_req(wfbt_pkg::MODE_UPDATE, 16'sd100);
		send_req(wfbt_pkg::MODE_UPDATE, 16'sd101);
		send_req(MODE_UNUSED, -16'sd1);
		configure(7'd0, 10'd2, 32'd0);           // window below 2 acts as 2
		for (int k = 0; k < 5; k++)
			send_req(wfbt_pkg::MODE_JUDGE, 16'sh5555 ^ {16{k[0]}});
		configure(7'd127, 10'd0, 32'hFFFF_FFFF); // window above max
		for (int k = 0; k < 66; k++)
			send_req((k % 3 == 0) ? wfbt_pkg::MODE_UPDATE : wfbt_pkg::MODE_JUDGE,
				clip16(k * 500 - 16000));

		// Random phases over a spread of settings and idle patterns.
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			case (p)
				0: configure(7'd2, 10'd0, 32'd0);
				1: configure(7'd64, 10'd0, 32'hFFFF_FFFF);
				2: configure(7'd16, 10'd3, 32'd16);
				3: configure(7'd1, 10'd1, 32'd100);
				4: configure(7'd127, 10'd0, 32'd5);
				5: configure(7'($urandom_range(63, 2)), 10'($urandom_range(8)),
					$urandom_range(2000));
				6: configure(7'd8, 10'd0, $urandom);
				default: configure(7'd33, 10'd2, 32'd1000);
			endcase
			random_traffic(38);
		end

		// Large start offset: a long smooth run in judge mode.
		idle_pct = 0;
		stall_pct = 0;
		configure(7'd5, 10'd250, 32'd50);
		send_req(wfbt_pkg::MODE_RESTART, 16'sd0);
		for (int k = 0; k < 262; k++)
			send_req(wfbt_pkg::MODE_JUDGE, clip16((k % 200) * 3 - 300));

		drain();
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("window_fit_baseline_tracker_top_tb passed");
		else
			$display("window_fit_baseline_tracker_top_tb failed");
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
hdl/wfbt_pkg.sv
hdl/window_fit_baseline_tracker_top.sv
bench/window_fit_baseline_tracker_top_tb.sv
